>>> sv/cse_pkg.sv
// shared types, character codes and helpers for the c string hex escaper
package cse_pkg;

  // input request: one raw byte and the fresh flag
  typedef struct packed {
    logic [7:0] in_byte;
    logic       fresh;
  } in_item_t;

  // result: one escaped character and the end-of-byte mark
  typedef struct packed {
    logic [6:0] out_char;
    logic       last;
  } out_item_t;

  // what the back end has to emit for one request
  typedef enum logic [1:0] {
    K_ONE  = 2'd0,   // the character itself
    K_PAIR = 2'd1,   // backslash, then the character
    K_HEX  = 2'd2    // backslash, x, two hex digits
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } cmd_t;

  // character codes
  localparam logic [6:0] CH_BSLASH = 7'h5C;
  localparam logic [6:0] CH_X      = 7'h78;
  localparam logic [6:0] CH_N      = 7'h6E;
  localparam logic [6:0] CH_R      = 7'h72;
  localparam logic [6:0] CH_QMARK  = 7'h3F;
  localparam logic [6:0] CH_DQUOTE = 7'h22;
  localparam logic [7:0] BYTE_LF   = 8'h0A;
  localparam logic [7:0] BYTE_CR   = 8'h0D;

  // upper-case hex digit for a nibble
  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    logic [6:0] wide;
    wide = {3'b000, nib};
    return (nib < 4'd10) ? (7'h30 + wide) : (7'h37 + wide);
  endfunction

  // true for 0-9, a-f, A-F
  function automatic logic is_hex_byte(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) ||
           ((c >= 8'h61) && (c <= 8'h66)) ||
           ((c >= 8'h41) && (c <= 8'h46));
  endfunction

endpackage

>>> sv/cse_front.sv
// front end: takes requests, tracks escape state and classifies each byte
module cse_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  cse_pkg::in_item_t in_item,
  input  logic              q_full,
  output logic              q_push,
  output cse_pkg::cmd_t     q_cmd
);

  typedef enum logic [2:0] {
    ST_NORMAL = 3'b001,
    ST_HEX    = 3'b010,
    ST_QMARK  = 3'b100
  } esc_state_t;

  logic       trig_r;
  esc_state_t state_r, state_nxt;
  esc_state_t prev;
  logic [7:0] c;
  logic       accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept;
  assign c        = in_item.in_byte;
  assign prev     = in_item.fresh ? ST_NORMAL : state_r;

  // trigraph mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_r <= 1'b0;
    end else if (cfg_we) begin
      trig_r <= cfg_wdata;
    end
  end

  // classify the byte
  always_comb begin
    q_cmd.kind = cse_pkg::K_HEX;
    q_cmd.data = c;
    state_nxt  = ST_HEX;
    if ((c >= 8'h20) && (c < 8'h7F) &&
        ((c == {1'b0, cse_pkg::CH_DQUOTE}) || (c == {1'b0, cse_pkg::CH_BSLASH}))) begin
      q_cmd.kind = cse_pkg::K_PAIR;
      state_nxt  = ST_NORMAL;
    end else if ((c == {1'b0, cse_pkg::CH_QMARK}) && trig_r) begin
      q_cmd.kind = (prev == ST_QMARK) ? cse_pkg::K_PAIR : cse_pkg::K_ONE;
      state_nxt  = ST_QMARK;
    end else if ((c >= 8'h20) && (c < 8'h7F) &&
                 !((prev == ST_HEX) && cse_pkg::is_hex_byte(c))) begin
      q_cmd.kind = cse_pkg::K_ONE;
      state_nxt  = ST_NORMAL;
    end else if (c == cse_pkg::BYTE_LF) begin
      q_cmd.kind = cse_pkg::K_PAIR;
      q_cmd.data = {1'b0, cse_pkg::CH_N};
      state_nxt  = ST_NORMAL;
    end else if (c == cse_pkg::BYTE_CR) begin
      q_cmd.kind = cse_pkg::K_PAIR;
      q_cmd.data = {1'b0, cse_pkg::CH_R};
      state_nxt  = ST_NORMAL;
    end
  end

  // escape state moves on every accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_NORMAL;
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> sv/cse_queue.sv
// small command queue between front and back end
module cse_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  cse_pkg::cmd_t push_cmd,
  input  logic          pop,
  output cse_pkg::cmd_t pop_cmd,
  output logic          full,
  output logic          empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  cse_pkg::cmd_t    mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = mem[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  // pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> sv/cse_back.sv
// back end: expands one command into its characters, one per cycle while not stalled
module cse_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  cse_pkg::cmd_t      q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output cse_pkg::out_item_t out_item
);

  cse_pkg::cmd_t      cur_r, cur_nxt;
  logic               cur_valid_r, cur_valid_nxt;
  logic [1:0]         step_r, step_nxt;
  logic               out_valid_r, out_valid_nxt;
  cse_pkg::out_item_t out_item_r, out_item_nxt;
  logic [6:0]         ch;
  logic               is_last;
  logic               load_out;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign load_out  = cur_valid_r && (!out_valid_r || !out_stall);
  assign q_pop     = !q_empty && (!cur_valid_r || (load_out && is_last));

  // character for the current step
  always_comb begin
    ch      = cur_r.data[6:0];
    is_last = 1'b1;
    unique case (cur_r.kind)
      cse_pkg::K_ONE: begin
        ch      = cur_r.data[6:0];
        is_last = 1'b1;
      end
      cse_pkg::K_PAIR: begin
        ch      = (step_r == 2'd0) ? cse_pkg::CH_BSLASH : cur_r.data[6:0];
        is_last = (step_r == 2'd1);
      end
      cse_pkg::K_HEX: begin
        is_last = (step_r == 2'd3);
        case (step_r)
          2'd0:    ch = cse_pkg::CH_BSLASH;
          2'd1:    ch = cse_pkg::CH_X;
          2'd2:    ch = cse_pkg::hex_char(cur_r.data[7:4]);
          default: ch = cse_pkg::hex_char(cur_r.data[3:0]);
        endcase
      end
      default: begin
        ch      = cur_r.data[6:0];
        is_last = 1'b1;
      end
    endcase
  end

  // current command and step
  always_comb begin
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    step_nxt      = step_r;
    if (q_pop) begin
      cur_nxt       = q_cmd;
      cur_valid_nxt = 1'b1;
      step_nxt      = 2'd0;
    end else if (load_out && is_last) begin
      cur_valid_nxt = 1'b0;
    end else if (load_out) begin
      step_nxt = step_r + 2'd1;
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (load_out) begin
      out_valid_nxt         = 1'b1;
      out_item_nxt.out_char = ch;
      out_item_nxt.last     = is_last;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    out_item_r <= out_item_nxt;
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      step_r      <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> sv/c_string_hex_escaper_unit.sv
// top level of the c string hex escaper: front end, command queue, back end
//
//  channel | direction | handshake           | payload
//  in      | request   | in_valid/in_stall   | in_item  (in_byte, fresh)
//  out     | result    | out_valid/out_stall | out_item (out_char, last)
//  cfg     | write     | cfg_we              | cfg_wdata (escape_trigraphs)
//
// each request yields 1 to 4 characters, one per cycle from the back end's
// output register while the output is not stalled.
// a request is taken every cycle while the command queue has room; it passes
// through the queue and the current command register before its first character shows.
// synchronous active-low reset clears escape state, trigraph mode, queue and valids.
// a stalled output holds its character; the queue absorbs requests until full.
module c_string_hex_escaper_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  cse_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output cse_pkg::out_item_t out_item
);

  logic          q_push, q_pop, q_full, q_empty;
  cse_pkg::cmd_t push_cmd, pop_cmd;

  // classification
  cse_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  // command queue
  cse_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  // character expansion
  cse_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_cmd     (pop_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // queue cannot be full and empty at once
  a_queue_flags: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_full && q_empty))
    else $error("queue full and empty together");

  // a request pushed into an empty queue is there the next cycle
  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && q_empty) |=> !q_empty)
    else $error("accepted request lost from queue");

  // after a taken character that is not last, the next one follows at once
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_item.last) |=> out_valid)
    else $error("gap inside the characters of one request");

endmodule
